FILE: sv/sprite_atlas_frame_sequencer_defines.svh
// Assertion macros for the sprite atlas frame sequencer.
// Included by the files that carry concurrent checks; expands to nothing under SYNTHESIS.
// The macros expect signals named clk and arst_n in the including scope.
`ifndef SPRITE_ATLAS_FRAME_SEQUENCER_DEFINES_SVH
`define SPRITE_ATLAS_FRAME_SEQUENCER_DEFINES_SVH
`ifndef SYNTHESIS
// Check that cons holds in the same cycle as ante.
`define SFS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Check that cons holds in the cycle after ante.
`define SFS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SFS_ASSERT_IMP(lbl, ante, cons, msg)
`define SFS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

FILE: sv/sfs_pkg.sv
// Shared types and constants of the sprite atlas frame sequencer.
// No dependencies; used by the channel interfaces and the top level.
package sfs_pkg;

	localparam int unsigned AnimSlots    = 32;
	localparam int unsigned CoordBits    = 12;
	localparam int unsigned FrameBits    = 8;
	localparam int unsigned DeltaBits    = 16;
	localparam int unsigned PeriodBits   = 16;
	localparam int unsigned AccBits      = 17;
	localparam int unsigned IndexBits    = 5;
	localparam int unsigned FuncBits     = 2;
	localparam int unsigned CfgIndexBits = 2;
	localparam int unsigned CfgBits      = 16;

	// Item kinds
	localparam logic [FuncBits-1:0] FUNC_TICK = 2'd0;
	localparam logic [FuncBits-1:0] FUNC_PLAY = 2'd1;
	localparam logic [FuncBits-1:0] FUNC_LOAD = 2'd2;

	// Configuration register indexes
	localparam logic [CfgIndexBits-1:0] CFG_FRAME_PERIOD   = 2'd0;
	localparam logic [CfgIndexBits-1:0] CFG_TEXTURE_WIDTH  = 2'd1;
	localparam logic [CfgIndexBits-1:0] CFG_TEXTURE_HEIGHT = 2'd2;

	typedef logic [CoordBits-1:0] coord_t;

	// Reset values of the configuration registers
	localparam logic [PeriodBits-1:0] PeriodRst = 16'd1;
	localparam coord_t                TexWRst   = '1;
	localparam coord_t                TexHRst   = '1;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t w;
		coord_t h;
	} rect_t;

	typedef struct packed {
		rect_t                rect;
		logic [FrameBits-1:0] frames;
		logic                 rpt;
	} anim_entry_t;

	typedef struct packed {
		logic [FuncBits-1:0]  func;
		logic [DeltaBits-1:0] delta;
		logic [IndexBits-1:0] anim_index;
		coord_t               entry_x;
		coord_t               entry_y;
		coord_t               entry_w;
		coord_t               entry_h;
		logic [FrameBits-1:0] entry_frame_count;
		logic                 entry_repeat;
	} item_t;

	typedef struct packed {
		logic [FrameBits-1:0] frame_number;
		coord_t               window_x;
		coord_t               window_y;
		coord_t               window_w;
		coord_t               window_h;
		logic                 playing;
		logic                 selected;
	} result_t;

endpackage

FILE: sv/sfs_item_if.sv
// Input channel of the sprite atlas frame sequencer: valid/ready plus one item word.
// Depends on sfs_pkg for the item type.
interface sfs_item_if import sfs_pkg::*; ();
	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: sv/sfs_result_if.sv
// Result channel of the sprite atlas frame sequencer: valid/ready plus one result word.
// Depends on sfs_pkg for the result type.
interface sfs_result_if import sfs_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: sv/sprite_atlas_frame_sequencer.sv
// Sprite atlas frame sequencer top level: animation table, playback state and channels.
// Depends on sfs_pkg, sfs_item_if, sfs_result_if and sprite_atlas_frame_sequencer_defines.svh.
//
// Usage:
//   The item channel takes one word per cycle while item.ready is high: a load appends
//   an animation entry to the table, a play selects an entry and restarts it, a tick adds
//   elapsed time and may step the draw window one frame. Every accepted word yields exactly
//   one result word holding the window, frame number and playing/selected flags after it.
//   Configuration (frame period, texture width and height) is written through cfg_wr_en,
//   cfg_index and cfg_data while the block is idle, which the user, not the block, ensures.
// Pipeline:
//   The accepting edge registers the word and reads the table into the input stage; the
//   stage's advance updates playback state and the result register together, and waits
//   while a result is unread. One word per cycle is sustained while result.ready is high.
// Reset:
//   arst_n clears the table fill count, the flags, the window and the accumulator, sets
//   the frame number to all ones and loads the configuration defaults. Table rows past the
//   fill count read as zero, so no clearing pass is needed.
// Stall:
//   While a result waits with result.ready low it holds; one more word is taken into the
//   input stage if that is empty, then item.ready drops until the result is taken.
`include "sprite_atlas_frame_sequencer_defines.svh"

module sprite_atlas_frame_sequencer import sfs_pkg::*; #(
	parameter int unsigned ANIM_SLOTS = AnimSlots
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wr_en,
	input  logic [CfgIndexBits-1:0] cfg_index,
	input  logic [CfgBits-1:0]      cfg_data,
	sfs_item_if.sink                item,
	sfs_result_if.source            result
);

	localparam int unsigned AW = (ANIM_SLOTS > 1) ? $clog2(ANIM_SLOTS) : 1;
	localparam int unsigned CW = $clog2(ANIM_SLOTS + 1);
	localparam int unsigned IW = (AW > IndexBits) ? AW : IndexBits;
	localparam int unsigned KW = ((CW > IndexBits) ? CW : IndexBits) + 1;
	localparam logic [CW-1:0]      SlotsCnt = CW'(ANIM_SLOTS);
	localparam logic [KW-1:0]      SlotsCmp = KW'(ANIM_SLOTS);
	localparam logic [AccBits-1:0] AccMax   = '1;

	// Configuration registers
	logic [PeriodBits-1:0] period_q;
	coord_t                tex_w_q;
	coord_t                tex_h_q;

	// Input stage
	logic              v_s1;
	item_t             item_s1;
	anim_entry_t       rd_s1;
	logic              play_ok_s1;
	logic              ent_ok_s1;
	logic              ld_ok_s1;
	logic [AW-1:0]     waddr_s1;
	logic [AW-1:0]     raddr_s1;
	logic [CW-1:0]     cnt_q;
	anim_entry_t       mem [ANIM_SLOTS];

	logic              adv;
	logic              acc_in;
	logic              ld_ok;
	logic [AW-1:0]     wr_addr;
	logic [IW-1:0]     idx_w;
	logic [AW-1:0]     rd_addr;
	logic [KW-1:0]     idx_k;
	anim_entry_t       wr_ent;

	// Playback state
	logic                 sel_q, sel_n;
	logic                 play_q, play_n;
	logic [FrameBits-1:0] frame_q, frame_n;
	logic [AccBits-1:0]   acc_q, acc_n;
	rect_t                win_q, win_n;
	logic [AW-1:0]        cur_q, cur_n;
	anim_entry_t          ent_q, ent_n;

	// Result register
	logic    res_v_q;
	result_t res_q;

	// Stage 2 working values
	anim_entry_t          rd_ent;
	anim_entry_t          s1_ent;
	logic [AccBits:0]     acc_sum;
	logic [AccBits-1:0]   acc_sat;
	logic [FrameBits-1:0] last_frame;
	logic [CoordBits:0]   nx;
	logic [CoordBits:0]   ny;
	logic [CoordBits:0]   yh;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PeriodRst;
			tex_w_q  <= TexWRst;
			tex_h_q  <= TexHRst;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_FRAME_PERIOD:   period_q <= cfg_data[PeriodBits-1:0];
				CFG_TEXTURE_WIDTH:  tex_w_q  <= cfg_data[CoordBits-1:0];
				CFG_TEXTURE_HEIGHT: tex_h_q  <= cfg_data[CoordBits-1:0];
				default: ;
			endcase
		end
	end

	// Handshake: input stage moves on when the result register is free or being taken
	assign adv        = v_s1 && (!res_v_q || result.ready);
	assign item.ready = !v_s1 || adv;
	assign acc_in     = item.valid && item.ready;

	// Table addressing
	assign ld_ok   = cnt_q < SlotsCnt;
	assign wr_addr = cnt_q[AW-1:0];
	assign idx_w   = IW'(item.data.anim_index);
	assign rd_addr = idx_w[AW-1:0];
	assign idx_k   = KW'(item.data.anim_index);
	assign wr_ent  = '{
		rect:   '{x: item.data.entry_x, y: item.data.entry_y,
			w: item.data.entry_w, h: item.data.entry_h},
		frames: item.data.entry_frame_count,
		rpt:    item.data.entry_repeat
	};

	// Write a loaded entry and read the entry a play may need, both at acceptance
	always_ff @(posedge clk) begin
		if (acc_in) begin
			if (item.data.func == FUNC_LOAD && ld_ok) begin
				mem[wr_addr] <= wr_ent;
			end
			rd_s1 <= mem[rd_addr];
		end
	end

	// Hold the accepted word and its table checks
	always_ff @(posedge clk) begin
		if (acc_in) begin
			item_s1    <= item.data;
			play_ok_s1 <= idx_k < SlotsCmp;
			ent_ok_s1  <= idx_k < KW'(cnt_q);
			ld_ok_s1   <= ld_ok;
			waddr_s1   <= wr_addr;
			raddr_s1   <= rd_addr;
		end
	end

	// Input stage valid and table fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (acc_in) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (acc_in && item.data.func == FUNC_LOAD && ld_ok) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Rows past the fill count were never loaded and read as zero
	assign rd_ent = ent_ok_s1 ? rd_s1 : '0;
	assign s1_ent = '{
		rect:   '{x: item_s1.entry_x, y: item_s1.entry_y,
			w: item_s1.entry_w, h: item_s1.entry_h},
		frames: item_s1.entry_frame_count,
		rpt:    item_s1.entry_repeat
	};

	// Accumulate, advance frame and step the window
	assign acc_sum    = {1'b0, acc_q} + (AccBits + 1)'(item_s1.delta);
	assign acc_sat    = (acc_sum > {1'b0, AccMax}) ? AccMax : acc_sum[AccBits-1:0];
	assign last_frame = ent_q.frames - 1'b1;
	assign yh         = {1'b0, win_q.y} + {1'b0, win_q.h};

	always_comb begin
		sel_n   = sel_q;
		play_n  = play_q;
		frame_n = frame_q;
		acc_n   = acc_q;
		win_n   = win_q;
		cur_n   = cur_q;
		ent_n   = ent_q;
		nx      = {1'b0, win_q.x} + {1'b0, win_q.w};
		ny      = {1'b0, win_q.y};
		case (item_s1.func)
			FUNC_TICK: begin
				if (sel_q && play_q) begin
					acc_n = acc_sat;
					if (acc_sat >= AccBits'(period_q)) begin
						acc_n = acc_sat - AccBits'(period_q);
						if (frame_q == last_frame) begin
							play_n = ent_q.rpt;
							if (ent_q.rpt) begin
								win_n   = ent_q.rect;
								frame_n = '0;
							end
						end else begin
							if (nx >= {1'b0, tex_w_q}) begin
								nx = '0;
								ny = yh;
							end
							if (ny >= {1'b0, tex_h_q}) begin
								ny = '0;
							end
							win_n.x = nx[CoordBits-1:0];
							win_n.y = ny[CoordBits-1:0];
							frame_n = frame_q + 1'b1;
						end
					end
				end
			end
			FUNC_PLAY: begin
				if (play_ok_s1) begin
					cur_n   = raddr_s1;
					sel_n   = 1'b1;
					play_n  = 1'b1;
					frame_n = '0;
					win_n   = rd_ent.rect;
					ent_n   = rd_ent;
				end
			end
			FUNC_LOAD: begin
				// keep the copy of the playing entry in step with a late load of its row
				if (ld_ok_s1 && waddr_s1 == cur_q) begin
					ent_n = s1_ent;
				end
			end
			default: ;
		endcase
	end

	// Playback state control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q   <= 1'b0;
			play_q  <= 1'b0;
			frame_q <= '1;
			acc_q   <= '0;
			win_q   <= '0;
			cur_q   <= '0;
			ent_q   <= '0;
		end else if (adv) begin
			sel_q   <= sel_n;
			play_q  <= play_n;
			frame_q <= frame_n;
			acc_q   <= acc_n;
			win_q   <= win_n;
			cur_q   <= cur_n;
			ent_q   <= ent_n;
		end
	end

	// Result register: load on advance, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (adv) begin
			res_v_q <= 1'b1;
		end else if (result.ready) begin
			res_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= '{
				frame_number: frame_n,
				window_x:     win_n.x,
				window_y:     win_n.y,
				window_w:     win_n.w,
				window_h:     win_n.h,
				playing:      play_n,
				selected:     sel_n
			};
		end
	end

	assign result.valid = res_v_q;
	assign result.data  = res_q;

	`SFS_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= SlotsCnt, "table fill count past slot count")
	`SFS_ASSERT_NXT(a_play_start, adv && item_s1.func == FUNC_PLAY && play_ok_s1, play_q && sel_q && frame_q == '0, "play did not restart animation")
	`SFS_ASSERT_NXT(a_acc_idle, !(sel_q && play_q), $stable(acc_q), "accumulator moved while not playing")
	`SFS_ASSERT_IMP(a_ready_full, !item.ready, v_s1 && res_v_q && !result.ready, "input stalled without a full pipe")
	`SFS_ASSERT_NXT(a_res_after_adv, adv, res_v_q, "advanced word lost its result")

endmodule

FILE: tb/sprite_atlas_frame_sequencer_tb.sv
// Self-checking testbench for sprite_atlas_frame_sequencer: directed table, then random phases.
// Depends on sfs_pkg, sfs_item_if, sfs_result_if and the top level; checks every word
// against a fixed expectation or an in-bench playback predictor.
`timescale 1ns / 1ps

module sprite_atlas_frame_sequencer_tb;
	import sfs_pkg::*;

	localparam logic [FuncBits-1:0] FUNC_NONE = 2'd3;
	localparam int unsigned RandItems = 450;
	localparam int unsigned NumPhases = 7;
	localparam int unsigned HoldCycles = 300;
	localparam int unsigned CycleLimit = 600000;

	localparam result_t VIEW_RESET = '{8'hFF, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0, 1'b0};
	localparam result_t VIEW_BLANK_PLAY = '{8'd0, 12'd0, 12'd0, 12'd0, 12'd0, 1'b1, 1'b1};
	localparam result_t VIEW_FULL_PLAY = '{8'd0, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 1'b1, 1'b1};

	typedef struct {
		item_t   it;
		bit      typed;
		result_t want;
	} plan_row_t;

	typedef struct {
		int unsigned period;
		int unsigned tex_w;
		int unsigned tex_h;
		int unsigned stall_pct;
		int unsigned gap_max;
	} phase_t;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_wr_en;
	logic [CfgIndexBits-1:0] cfg_index;
	logic [CfgBits-1:0]      cfg_data;

	sfs_item_if   item_ch ();
	sfs_result_if result_ch ();

	sprite_atlas_frame_sequencer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item_ch),
		.result    (result_ch)
	);

	// Playback predictor state
	anim_entry_t            p_table [AnimSlots];
	logic [5:0]             p_count;
	logic [IndexBits-1:0]   p_cur;
	logic                   p_sel;
	logic                   p_play;
	logic [FrameBits-1:0]   p_frame;
	logic [AccBits-1:0]     p_acc;
	rect_t                  p_win;
	logic [PeriodBits-1:0]  cfg_period;
	coord_t                 cfg_tex_w;
	coord_t                 cfg_tex_h;

	result_t     view_q[$];
	plan_row_t   plan[$];
	int unsigned mismatches = 0;
	int unsigned cycles = 0;
	int unsigned burst_left = 0;
	int unsigned gap_max = 0;
	int unsigned stall_pct = 0;
	bit          hold_req = 0;

	// Step the window one frame, or end/restart the animation on its last frame
	function automatic void step_frame();
		anim_entry_t          e;
		logic [FrameBits-1:0] last;
		logic [CoordBits:0]   nx;
		logic [CoordBits:0]   ny;
		e = p_table[p_cur];
		last = e.frames - 8'd1;
		if (p_frame == last) begin
			p_play = e.rpt;
			if (e.rpt) begin
				p_win = e.rect;
				p_frame = '0;
			end
			return;
		end
		nx = {1'b0, p_win.x} + p_win.w;
		ny = {1'b0, p_win.y};
		if (nx >= cfg_tex_w) begin
			nx = '0;
			ny = {1'b0, p_win.y} + p_win.h;
		end
		if (ny >= cfg_tex_h)
			ny = '0;
		p_win.x = nx[CoordBits-1:0];
		p_win.y = ny[CoordBits-1:0];
		p_frame = p_frame + 8'd1;
	endfunction

	// Apply one word to the predictor; return 1 for a tick while playing, a play, or a load with room
	function automatic bit predict_view(input item_t it, output result_t view);
		logic [AccBits:0] sum;
		bit               useful;
		useful = 1'b0;
		case (it.func)
			FUNC_TICK: begin
				if (p_sel && p_play) begin
					useful = 1'b1;
					sum = p_acc + it.delta;
					if (sum > 18'h1FFFF)
						sum = 18'h1FFFF;
					p_acc = sum[AccBits-1:0];
					if (p_acc >= cfg_period) begin
						p_acc = p_acc - cfg_period;
						step_frame();
					end
				end
			end
			FUNC_PLAY: begin
				useful = 1'b1;
				p_cur = it.anim_index;
				p_sel = 1'b1;
				p_win = p_table[it.anim_index].rect;
				p_play = 1'b1;
				p_frame = '0;
			end
			FUNC_LOAD: begin
				if (p_count < AnimSlots) begin
					useful = 1'b1;
					p_table[p_count[IndexBits-1:0]] = '{
						rect: '{it.entry_x, it.entry_y, it.entry_w, it.entry_h},
						frames: it.entry_frame_count,
						rpt: it.entry_repeat
					};
					p_count = p_count + 6'd1;
				end
			end
			default: ;
		endcase
		view = '{p_frame, p_win.x, p_win.y, p_win.w, p_win.h, p_play, p_sel};
		return useful;
	endfunction

	function automatic plan_row_t mk(input logic [FuncBits-1:0] f, input int unsigned delta,
			input int unsigned idx, input int unsigned x, input int unsigned y,
			input int unsigned w, input int unsigned h, input int unsigned fc,
			input int unsigned rp, input bit typed, input result_t want);
		plan_row_t row;
		row.it = '{f, delta[DeltaBits-1:0], idx[IndexBits-1:0], x[CoordBits-1:0],
			y[CoordBits-1:0], w[CoordBits-1:0], h[CoordBits-1:0], fc[FrameBits-1:0], rp[0]};
		row.typed = typed;
		row.want = want;
		return row;
	endfunction

	// Random word, mostly play-then-tick sequences with some loads and noise
	function automatic item_t make_item();
		item_t       it;
		int unsigned r;
		it.func = FUNC_TICK;
		it.delta = DeltaBits'($urandom);
		it.anim_index = IndexBits'($urandom);
		it.entry_x = CoordBits'($urandom);
		it.entry_y = CoordBits'($urandom);
		it.entry_w = CoordBits'($urandom);
		it.entry_h = CoordBits'($urandom);
		it.entry_frame_count = FrameBits'($urandom);
		it.entry_repeat = 1'($urandom);
		r = $urandom_range(0, 99);
		if (r < 3) begin
			it.func = FUNC_NONE;
		end else if (r < 13) begin
			it.func = FUNC_LOAD;
			if ($urandom_range(0, 1) != 0) begin
				it.entry_w = CoordBits'($urandom_range(0, 300));
				it.entry_h = CoordBits'($urandom_range(0, 300));
				it.entry_frame_count = FrameBits'($urandom_range(1, 6));
			end
		end else if (r < (p_play ? 25 : 55)) begin
			it.func = FUNC_PLAY;
			if (p_count != 0 && $urandom_range(0, 4) != 0)
				it.anim_index = IndexBits'($urandom_range(0, p_count - 1));
		end else begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: it.delta = DeltaBits'($urandom_range(0, cfg_period));
				4, 5: ;
				6: it.delta = '0;
				7: it.delta = '1;
				default: it.delta = cfg_period;
			endcase
		end
		return it;
	endfunction

	// Offer one word, honoring the burst/gap pattern; predict on acceptance
	task automatic send(input item_t it, input bit typed, input result_t want);
		result_t view;
		if (gap_max != 0) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 16);
				item_ch.valid <= 1'b0;
				repeat ($urandom_range(1, gap_max)) @(negedge clk);
			end
			burst_left--;
		end
		item_ch.valid <= 1'b1;
		item_ch.data <= it;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		void'(predict_view(it, view));
		view_q.push_back(typed ? want : view);
		@(negedge clk);
	endtask

	// Stop offering and wait until every expected word has come back
	task automatic drain();
		item_ch.valid <= 1'b0;
		while (view_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CfgIndexBits-1:0] idx, input logic [CfgBits-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_FRAME_PERIOD:   cfg_period = val;
			CFG_TEXTURE_WIDTH:  cfg_tex_w = val[CoordBits-1:0];
			CFG_TEXTURE_HEIGHT: cfg_tex_h = val[CoordBits-1:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver: random stalls, plus one long hold-off on request
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				result_ch.ready <= 1'b0;
				repeat (HoldCycles) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	// Compare each returned word with the oldest expectation
	always @(posedge clk) begin
		result_t want;
		result_t got;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got = result_ch.data;
			if (view_q.size() == 0) begin
				$error("result word with no expectation pending");
				mismatches++;
			end else begin
				want = view_q.pop_front();
				check_field("frame_number", want.frame_number, got.frame_number);
				check_field("window_x", want.window_x, got.window_x);
				check_field("window_y", want.window_y, got.window_y);
				check_field("window_w", want.window_w, got.window_w);
				check_field("window_h", want.window_h, got.window_h);
				check_field("playing", want.playing, got.playing);
				check_field("selected", want.selected, got.selected);
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("FAIL sprite_atlas_frame_sequencer");
			$finish;
		end
	end

	// Main sequence
	initial begin
		phase_t      phases [NumPhases];
		int unsigned goal;
		int unsigned sent;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		item_ch.valid = 1'b0;
		item_ch.data = '0;

		// Predictor starts from the reset state
		foreach (p_table[i])
			p_table[i] = '0;
		p_count = '0;
		p_cur = '0;
		p_sel = 1'b0;
		p_play = 1'b0;
		p_frame = 8'hFF;
		p_acc = '0;
		p_win = '0;
		cfg_period = PeriodRst;
		cfg_tex_w = TexWRst;
		cfg_tex_h = TexHRst;

		// Directed words under the reset configuration
		plan.push_back(mk(FUNC_TICK, 16'h1234, 0, 0, 0, 0, 0, 0, 0, 1, VIEW_RESET));
		plan.push_back(mk(FUNC_NONE, 16'hFFFF, 31, 7, 7, 7, 7, 7, 1, 1, VIEW_RESET));
		plan.push_back(mk(FUNC_LOAD, 0, 0, 4095, 4095, 4095, 4095, 255, 1, 1, VIEW_RESET));
		plan.push_back(mk(FUNC_LOAD, 0, 0, 0, 0, 0, 0, 0, 0, 1, VIEW_RESET));
		plan.push_back(mk(FUNC_LOAD, 0, 0, 100, 200, 1000, 2000, 2, 0, 0, '0));
		plan.push_back(mk(FUNC_LOAD, 0, 0, 3000, 10, 1500, 20, 3, 1, 0, '0));
		plan.push_back(mk(FUNC_PLAY, 0, 31, 0, 0, 0, 0, 0, 0, 1, VIEW_BLANK_PLAY));
		plan.push_back(mk(FUNC_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, '0));
		plan.push_back(mk(FUNC_TICK, 1, 0, 0, 0, 0, 0, 0, 0, 0, '0));
		plan.push_back(mk(FUNC_PLAY, 0, 0, 0, 0, 0, 0, 0, 0, 1, VIEW_FULL_PLAY));
		plan.push_back(mk(FUNC_TICK, 65535, 0, 0, 0, 0, 0, 0, 0, 0, '0));
		plan.push_back(mk(FUNC_TICK, 65535, 0, 0, 0, 0, 0, 0, 0, 0, '0));
		plan.push_back(mk(FUNC_PLAY, 0, 2, 0, 0, 0, 0, 0, 0, 0, '0));
		plan.push_back(mk(FUNC_TICK, 1, 0, 0, 0, 0, 0, 0, 0, 0, '0));
		plan.push_back(mk(FUNC_TICK, 1, 0, 0, 0, 0, 0, 0, 0, 0, '0));
		plan.push_back(mk(FUNC_TICK, 5, 0, 0, 0, 0, 0, 0, 0, 0, '0));
		plan.push_back(mk(FUNC_PLAY, 0, 3, 0, 0, 0, 0, 0, 0, 0, '0));
		plan.push_back(mk(FUNC_TICK, 1, 0, 0, 0, 0, 0, 0, 0, 0, '0));
		plan.push_back(mk(FUNC_TICK, 1, 0, 0, 0, 0, 0, 0, 0, 0, '0));
		plan.push_back(mk(FUNC_TICK, 1, 0, 0, 0, 0, 0, 0, 0, 0, '0));
		plan.push_back(mk(FUNC_TICK, 1, 0, 0, 0, 0, 0, 0, 0, 0, '0));
		plan.push_back(mk(FUNC_PLAY, 0, 1, 0, 0, 0, 0, 0, 0, 0, '0));
		plan.push_back(mk(FUNC_TICK, 1, 0, 0, 0, 0, 0, 0, 0, 0, '0));

		// Configuration per random phase, extremes included
		phases[0] = '{0, 4095, 4095, 0, 0};
		phases[1] = '{65535, 1, 1, 30, 4};
		phases[2] = '{3, 640, 480, 50, 6};
		phases[3] = '{0, 0, 0, 20, 3};
		phases[4] = '{100, 4095, 1, 70, 2};
		phases[5] = '{1, 1, 4095, 10, 8};
		phases[6] = '{$urandom_range(0, 40), $urandom_range(1, 4095), $urandom_range(1, 4095),
			40, 5};

		// Hold reset, then release on a falling edge
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Walk the directed table
		stall_pct = 25;
		gap_max = 3;
		foreach (plan[i])
			send(plan[i].it, plan[i].typed, plan[i].want);
		drain();

		// Random phases, reprogrammed while idle
		for (int ph = 0; ph < NumPhases; ph++) begin
			write_reg(CFG_FRAME_PERIOD, PeriodBits'(phases[ph].period));
			write_reg(CFG_TEXTURE_WIDTH, {4'($urandom), phases[ph].tex_w[CoordBits-1:0]});
			write_reg(CFG_TEXTURE_HEIGHT, {4'($urandom), phases[ph].tex_h[CoordBits-1:0]});
			cfg_wr_en <= 1'b0;
			@(negedge clk);
			stall_pct = phases[ph].stall_pct;
			gap_max = phases[ph].gap_max;
			burst_left = 0;
			goal = (ph + 1) * RandItems / NumPhases - ph * RandItems / NumPhases;
			sent = 0;
			while (sent < goal) begin
				// Long receiver hold-off while words keep coming
				if (ph == 2 && sent == 20)
					hold_req = 1'b1;
				// Sender pause until everything is back
				if (ph == 3 && sent == 20)
					drain();
				send(make_item(), 1'b0, '0);
				sent++;
			end
			drain();
		end

		repeat (8) @(posedge clk);
		if (mismatches == 0 && view_q.size() == 0) begin
			$display("PASS sprite_atlas_frame_sequencer");
		end else begin
			$display("FAIL sprite_atlas_frame_sequencer");
		end
		$finish;
	end

endmodule
